// File: rtl/dssc_pkg.sv
// shared types, constants and codes for the debounced solenoid shift controller
// no dependencies

package dssc_pkg;

  localparam int CountWidth = 16;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxWidth = 2;
  localparam int CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_t;
  typedef logic [CmpWidth-1:0]   cmp_t;

  localparam count_t CountMax = '1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDebounceTicks = 2'd0,
    CfgTimeoutTicks  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ReqTick    = 2'd0,
    ReqUpEdge  = 2'd1,
    ReqDownEdge = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    PhReleased   = 2'd0,
    PhChkPress   = 2'd1,
    PhPressed    = 2'd2,
    PhChkRelease = 2'd3
  } deb_phase_e;

  typedef enum logic [2:0] {
    ModeIdle      = 3'd0,
    ModeUpReq     = 3'd1,
    ModeDownDrive = 3'd2,
    ModeDownReq   = 3'd3,
    ModeUpDrive   = 3'd4
  } shift_mode_e;

  typedef enum logic [1:0] {
    PistonCentre  = 2'd0,
    PistonUp      = 2'd1,
    PistonDown    = 2'd2,
    PistonBetween = 2'd3
  } piston_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       up_button_level;
    logic       down_button_level;
    logic [1:0] piston_position;
  } in_item_t;

  typedef struct packed {
    logic       up_solenoid_on;
    logic       down_solenoid_on;
    logic [2:0] shift_phase;
    logic       up_shift_started;
    logic       down_shift_started;
    logic [1:0] up_button_status;
    logic [1:0] down_button_status;
  } out_item_t;

  typedef struct packed {
    deb_phase_e phase;
    count_t     cnt;
    logic       accepted;
  } deb_t;

  function automatic logic cnt_below(count_t cnt, cfg_t ticks);
    return cmp_t'(cnt) < cmp_t'(ticks);
  endfunction

  function automatic deb_t deb_edge(deb_t cur, cfg_t ticks);
    deb_t r;
    r = cur;
    r.accepted = 1'b0;
    if (r.phase == PhChkPress && cnt_below(r.cnt, ticks)) r.phase = PhReleased;
    if (r.phase == PhChkRelease && cnt_below(r.cnt, ticks)) r.phase = PhPressed;
    if (r.phase == PhReleased) begin
      r.cnt   = '0;
      r.phase = PhChkPress;
    end else if (r.phase == PhPressed) begin
      r.cnt   = '0;
      r.phase = PhChkRelease;
    end
    return r;
  endfunction

  function automatic deb_t deb_tick(deb_t cur, logic level, cfg_t ticks);
    deb_t r;
    logic grow;
    r = cur;
    r.accepted = 1'b0;
    grow = (r.phase == PhChkPress && level) || (r.phase == PhChkRelease && !level);
    if (grow && r.cnt != CountMax) r.cnt = r.cnt + count_t'(1);
    if (r.phase == PhPressed && !level) begin
      r.phase = PhChkRelease;
      r.cnt   = '0;
    end
    if (r.phase == PhChkPress && !cnt_below(r.cnt, ticks)) begin
      r.phase    = PhPressed;
      r.cnt      = '0;
      r.accepted = 1'b1;
    end
    if (r.phase == PhChkRelease && !cnt_below(r.cnt, ticks)) r.phase = PhReleased;
    return r;
  endfunction

  function automatic count_t timeout_load(cfg_t timeout);
    cmp_t t;
    t = cmp_t'(timeout);
    return (t > cmp_t'(CountMax)) ? CountMax : count_t'(t);
  endfunction

endpackage

// File: rtl/dssc_in_if.sv
// input item channel: valid, ready and payload
// depends on dssc_pkg

interface dssc_in_if;
  import dssc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dssc_out_if.sv
// result item channel: valid, ready and payload
// depends on dssc_pkg

interface dssc_out_if;
  import dssc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/debounced_solenoid_shift_controller_top.sv
// debounced two-button solenoid shift controller, top level
// depends on dssc_pkg, dssc_in_if, dssc_out_if
//
// channel   | dir | transfer when       | payload
// item_i    | in  | valid && ready      | req_type, button levels, piston_position
// result_o  | out | valid && ready      | solenoid drives, shift_phase, started, status
// cfg       | in  | cfg_we_i            | cfg_idx_i selects register, cfg_data_i value
//
// one item per cycle while result_o is not stalled; a transferred item is registered in the
// input register, then its state update is registered into the result register
// reset clears the state, both stages and the config registers to their defaults
// a stalled result holds the result register, then the input register, then item_i.ready

module debounced_solenoid_shift_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dssc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [dssc_pkg::CfgWidth-1:0]    cfg_data_i,
  dssc_in_if.sink                     item_i,
  dssc_out_if.source                  result_o
);
  import dssc_pkg::*;

  cfg_t        debounce_ticks_q, timeout_ticks_q;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  deb_phase_e  up_phase_q, dn_phase_q;
  count_t      up_cnt_q, dn_cnt_q;
  shift_mode_e mode_q, mode_d;
  count_t      dn_timer_q, up_timer_q, dn_timer_d, up_timer_d;
  deb_t        up_d, dn_d;
  logic        up_started, dn_started;
  logic        s1_adv;
  out_item_t   res_d;

  assign s1_adv       = !out_valid_q || result_o.ready;
  assign item_i.ready = !in_valid_q || s1_adv;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= cfg_t'(20);
      timeout_ticks_q  <= cfg_t'(200);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounceTicks: debounce_ticks_q <= cfg_data_i;
        CfgTimeoutTicks:  timeout_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) in_item_q <= item_i.data;
  end

  // item update
  always_comb begin
    deb_t up_cur, dn_cur;
    up_cur = '{phase: up_phase_q, cnt: up_cnt_q, accepted: 1'b0};
    dn_cur = '{phase: dn_phase_q, cnt: dn_cnt_q, accepted: 1'b0};
    up_d       = up_cur;
    dn_d       = dn_cur;
    mode_d     = mode_q;
    dn_timer_d = dn_timer_q;
    up_timer_d = up_timer_q;
    up_started = 1'b0;
    dn_started = 1'b0;

    unique case (in_item_q.req_type)
      ReqUpEdge:   up_d = deb_edge(up_cur, debounce_ticks_q);
      ReqDownEdge: dn_d = deb_edge(dn_cur, debounce_ticks_q);
      ReqTick: begin
        if (dn_timer_q != '0) dn_timer_d = dn_timer_q - count_t'(1);
        if (up_timer_q != '0) up_timer_d = up_timer_q - count_t'(1);
        up_d = deb_tick(up_cur, in_item_q.up_button_level, debounce_ticks_q);
        dn_d = deb_tick(dn_cur, in_item_q.down_button_level, debounce_ticks_q);
        if (up_d.accepted && in_item_q.piston_position == PistonCentre
            && mode_d == ModeIdle) begin
          mode_d     = ModeUpReq;
          up_started = 1'b1;
        end
        if (dn_d.accepted && in_item_q.piston_position == PistonCentre
            && mode_d == ModeIdle) begin
          mode_d     = ModeDownReq;
          dn_started = 1'b1;
        end
      end
      default: ;
    endcase

    // main-loop step
    unique case (mode_d)
      ModeUpReq: begin
        dn_timer_d = timeout_load(timeout_ticks_q);
        mode_d     = ModeDownDrive;
      end
      ModeDownDrive: begin
        if (in_item_q.piston_position == PistonUp || dn_timer_d == '0) mode_d = ModeIdle;
      end
      ModeDownReq: begin
        up_timer_d = timeout_load(timeout_ticks_q);
        mode_d     = ModeUpDrive;
      end
      ModeUpDrive: begin
        if (in_item_q.piston_position == PistonDown || up_timer_d == '0) mode_d = ModeIdle;
      end
      default: ;
    endcase

    res_d.up_solenoid_on     = (mode_d == ModeUpDrive);
    res_d.down_solenoid_on   = (mode_d == ModeDownDrive);
    res_d.shift_phase        = mode_d;
    res_d.up_shift_started   = up_started;
    res_d.down_shift_started = dn_started;
    res_d.up_button_status   = up_d.phase;
    res_d.down_button_status = dn_d.phase;
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_phase_q  <= PhReleased;
      dn_phase_q  <= PhReleased;
      up_cnt_q    <= '0;
      dn_cnt_q    <= '0;
      mode_q      <= ModeIdle;
      dn_timer_q  <= '0;
      up_timer_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        up_phase_q <= up_d.phase;
        dn_phase_q <= dn_d.phase;
        up_cnt_q   <= up_d.cnt;
        dn_cnt_q   <= dn_d.cnt;
        mode_q     <= mode_d;
        dn_timer_q <= dn_timer_d;
        up_timer_q <= up_timer_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_q) out_item_q <= res_d;
  end

endmodule
